// File: rtl/weighted_loss_average_unit_defines.svh
// Assertion macros shared by the weighted loss average unit.
`ifndef WEIGHTED_LOSS_AVERAGE_UNIT_DEFINES_SVH
`define WEIGHTED_LOSS_AVERAGE_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WLA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WLA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/wla_pkg.sv
// Types and constants shared by the weighted loss average unit.
`timescale 1ns / 1ps

package wla_pkg;

	localparam int RATIO_W   = 17;
	localparam int ENTRIES_W = 5;
	localparam logic [RATIO_W-1:0] RATIO_ONE = 17'h10000;

	typedef enum logic [2:0] {
		WLA_IDLE,
		WLA_WALK,
		WLA_DRAIN,
		WLA_DIVIDE,
		WLA_HOLD
	} wla_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic insert;
		logic walk;
		logic div_step;
		logic load_out;
	} wla_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic walk_last;
		logic div_last;
		logic out_free;
	} wla_stat_t;

endpackage

// File: rtl/wla_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module wla_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 24
) (
	input  logic                                 clk,
	input  logic                                 wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                     wr_data,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                     rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

// File: rtl/wla_datapath.sv
// Datapath: history store, window pointers, weighted sum and serial divider.
`timescale 1ns / 1ps
`include "weighted_loss_average_unit_defines.svh"

module wla_datapath import wla_pkg::*; #(
	parameter int WINDOW_DEPTH = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  wla_cmd_t             cmd,
	output wla_stat_t            stat,
	input  logic [RATIO_W-1:0]   loss_ratio,
	input  logic                 result_stall,
	output logic                 result_valid,
	output logic [RATIO_W-1:0]   average_loss,
	output logic [ENTRIES_W-1:0] entries_held
);

	localparam int IDX_W   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int CNT_W   = $clog2(WINDOW_DEPTH + 1);
	localparam int PTR_W   = CNT_W + 1;
	localparam int DIV_MAX = WINDOW_DEPTH * (WINDOW_DEPTH + 1) / 2;
	localparam int DIV_W   = $clog2(DIV_MAX + 1);
	localparam int S_W     = $clog2(WINDOW_DEPTH * 65536 + 1);
	localparam int SUM_W   = $clog2(DIV_MAX * 65536 + 1);
	localparam int DCNT_W  = $clog2(SUM_W);

	localparam logic [PTR_W-1:0]  DEPTH_P   = PTR_W'(WINDOW_DEPTH);
	localparam logic [CNT_W-1:0]  DEPTH_C   = CNT_W'(WINDOW_DEPTH);
	localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(WINDOW_DEPTH - 1);
	localparam logic [DCNT_W-1:0] DIV_LAST  = DCNT_W'(SUM_W - 1);

	logic [CNT_W-1:0]  fill_q;
	logic [IDX_W-1:0]  oldest_q;
	logic [DIV_W-1:0]  tri_q;
	logic [IDX_W-1:0]  walk_addr_q;
	logic [CNT_W-1:0]  walk_cnt_q;
	logic              rd_valid_s1;
	logic [S_W-1:0]    s_q;
	logic [SUM_W-1:0]  t_q;
	logic [DIV_W:0]    rem_q;
	logic [DCNT_W-1:0] div_cnt_q;
	logic              out_valid_q;
	logic [RATIO_W-1:0]   avg_q;
	logic [ENTRIES_W-1:0] entries_q;

	logic [RATIO_W-1:0] ratio_sat;
	logic               full;
	logic [PTR_W-1:0]   slot_sum;
	logic [IDX_W-1:0]   wr_slot;
	logic [CNT_W-1:0]   fill_nxt;
	logic [RATIO_W-1:0] hist_rdata;
	logic [S_W-1:0]     s_nxt;
	logic [DIV_W:0]     rem_sh;
	logic               rem_ge;

	assign ratio_sat = (loss_ratio > RATIO_ONE) ? RATIO_ONE : loss_ratio;
	assign full      = (fill_q == DEPTH_C);
	assign slot_sum  = PTR_W'(oldest_q) + PTR_W'(fill_q);
	assign fill_nxt  = fill_q + 1'b1;

	always_comb begin
		if (full) begin
			wr_slot = oldest_q;
		end else if (slot_sum >= DEPTH_P) begin
			wr_slot = IDX_W'(slot_sum - DEPTH_P);
		end else begin
			wr_slot = IDX_W'(slot_sum);
		end
	end

	wla_ram #(
		.WIDTH(RATIO_W),
		.DEPTH(WINDOW_DEPTH)
	) u_hist (
		.clk     (clk),
		.wr_en   (cmd.insert),
		.wr_addr (wr_slot),
		.wr_data (ratio_sat),
		.rd_addr (walk_addr_q),
		.rd_data (hist_rdata)
	);

	// Walking newest to oldest, s accumulates the suffix sum and t the sum of
	// suffix sums, so the newest entry is counted n times and the oldest once.
	assign s_nxt  = s_q + S_W'(hist_rdata);
	assign rem_sh = {rem_q[DIV_W-1:0], t_q[SUM_W-1]};
	assign rem_ge = (rem_sh >= {1'b0, tri_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			oldest_q    <= '0;
			tri_q       <= '0;
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_valid_s1 <= cmd.walk;
			if (cmd.insert) begin
				if (full) begin
					oldest_q <= (oldest_q == LAST_IDX) ? '0 : oldest_q + 1'b1;
				end else begin
					fill_q <= fill_nxt;
					tri_q  <= tri_q + DIV_W'(fill_nxt);
				end
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.insert) begin
			walk_addr_q <= wr_slot;
			walk_cnt_q  <= '0;
			s_q         <= '0;
			t_q         <= '0;
			rem_q       <= '0;
			div_cnt_q   <= '0;
		end else begin
			if (cmd.walk) begin
				walk_addr_q <= (walk_addr_q == '0) ? LAST_IDX : walk_addr_q - 1'b1;
				walk_cnt_q  <= walk_cnt_q + 1'b1;
			end
			if (rd_valid_s1) begin
				s_q <= s_nxt;
				t_q <= t_q + SUM_W'(s_nxt);
			end else if (cmd.div_step) begin
				rem_q     <= rem_ge ? rem_sh - {1'b0, tri_q} : rem_sh;
				t_q       <= {t_q[SUM_W-2:0], rem_ge};
				div_cnt_q <= div_cnt_q + 1'b1;
			end
		end
		if (cmd.load_out) begin
			avg_q     <= RATIO_W'(t_q);
			entries_q <= ENTRIES_W'(fill_q);
		end
	end

	assign stat.walk_last = (walk_cnt_q + 1'b1 == fill_q);
	assign stat.div_last  = (div_cnt_q == DIV_LAST);
	assign stat.out_free  = !out_valid_q || !result_stall;

	assign result_valid = out_valid_q;
	assign average_loss = avg_q;
	assign entries_held = entries_q;

	`WLA_ASSERT_NOW(a_fill_bound, clk, arst_n, 1'b1, fill_q <= DEPTH_C,
		"fill count beyond window depth")
	`WLA_ASSERT_NOW(a_divisor_track, clk, arst_n, 1'b1,
		32'(tri_q) == 32'(fill_q) * (32'(fill_q) + 32'd1) / 32'd2,
		"divisor out of step with fill count")
	`WLA_ASSERT_NOW(a_quot_range, clk, arst_n, cmd.load_out,
		t_q <= SUM_W'(RATIO_ONE), "average above one")

endmodule

// File: rtl/wla_ctrl.sv
// Controller: sequences insert, history walk, division and result hand-over.
`timescale 1ns / 1ps
`include "weighted_loss_average_unit_defines.svh"

module wla_ctrl import wla_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      loss_valid,
	output logic      loss_stall,
	input  wla_stat_t stat,
	output wla_cmd_t  cmd
);

	wla_state_t state_q;
	wla_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= WLA_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		unique case (state_q)
			WLA_IDLE: begin
				if (loss_valid) begin
					cmd.insert = 1'b1;
					state_nxt  = WLA_WALK;
				end
			end
			WLA_WALK: begin
				cmd.walk = 1'b1;
				if (stat.walk_last) begin
					state_nxt = WLA_DRAIN;
				end
			end
			WLA_DRAIN: begin
				state_nxt = WLA_DIVIDE;
			end
			WLA_DIVIDE: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_nxt = WLA_HOLD;
				end
			end
			WLA_HOLD: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_nxt    = WLA_IDLE;
				end
			end
			default: begin
				state_nxt = WLA_IDLE;
			end
		endcase
	end

	assign loss_stall = (state_q != WLA_IDLE);

	`WLA_ASSERT_NEXT(a_drain_to_div, clk, arst_n, state_q == WLA_DRAIN,
		state_q == WLA_DIVIDE, "drain not followed by division")
	`WLA_ASSERT_NOW(a_load_free, clk, arst_n, cmd.load_out, stat.out_free,
		"result loaded over an untaken result")

endmodule

// File: rtl/weighted_loss_average_unit.sv
// Top level of the weighted loss average unit.
`timescale 1ns / 1ps

// Channel  | Handshake                  | Payload
// ---------+----------------------------+------------------------------------
// loss     | loss_valid / loss_stall    | loss_ratio (17 bits, Q1.16)
// result   | result_valid / result_stall| average_loss (17 bits), entries_held
//
// Each loss ratio transaction runs from acceptance through the insert, a walk
// over the n entries held after the insert, a drain state, a division with
// one step per bit of the W-bit weighted sum (25 bits at the default depth
// of 24) and the result hand-over; the next loss ratio is accepted in idle.
// The walk reads one entry a cycle through the single read port of the
// history RAM, and the restoring divider retires one quotient bit a cycle.
// Reset empties the window and the result register; the history RAM itself
// is not cleared, as only written entries are ever walked. A waiting result
// does not block the next loss transaction: only when a new result is ready
// while the previous one is still stalled does the unit hold it back.

module weighted_loss_average_unit import wla_pkg::*; #(
	parameter int WINDOW_DEPTH = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 loss_valid,
	output logic                 loss_stall,
	input  logic [RATIO_W-1:0]   loss_ratio,
	output logic                 result_valid,
	input  logic                 result_stall,
	output logic [RATIO_W-1:0]   average_loss,
	output logic [ENTRIES_W-1:0] entries_held
);

	wla_cmd_t  cmd;
	wla_stat_t stat;

	// The controller only moves from idle on a valid loss ratio, so the
	// insert command coincides with the accepting edge.
	wla_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.loss_valid (loss_valid),
		.loss_stall (loss_stall),
		.stat       (stat),
		.cmd        (cmd)
	);

	// The datapath keeps the window, forms the weighted sum by a running
	// suffix sum, divides it by n(n+1)/2 and owns the result register.
	wla_datapath #(
		.WINDOW_DEPTH(WINDOW_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.loss_ratio   (loss_ratio),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.average_loss (average_loss),
		.entries_held (entries_held)
	);

endmodule
